// ===== hw/rtl/mqnm_pkg.sv =====
// Shared types and constants of the mDNS query name matcher.
// Used by the loader, the scanner and the top level; depends on nothing.
package mqnm_pkg;

	localparam int DEF_MAX_PACKET_BYTES = 1500;
	localparam int DEF_NAME_CHARS = 32;
	localparam int DEF_STEP_LIMIT = 64;
	localparam int DEF_DECODED_LIMIT = 256;

	localparam int OFF_W = 16;
	localparam int HDR_BYTES = 12;
	localparam int QTYPE_A = 1;
	localparam int QTYPE_ANY = 255;
	localparam int QR_BIT = 7;
	localparam logic [7:0] DOT_CHAR = 8'h2e;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_NAME_REGS = 4;
	localparam int CFG_CHARS_PER_REG = 8;
	localparam int CFG_NAME_LEN_W = 6;
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_LENGTH = 3'd4;

	typedef enum logic [1:0] {
		V_SHORT = 2'd0,
		V_RESPONSE = 2'd1,
		V_NO_MATCH = 2'd2,
		V_ANSWER = 2'd3
	} verdict_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		fold_case = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

endpackage

// ===== hw/rtl/mqnm_store.sv =====
// Packet byte store: one write port, one read port with registered data.
// Depends on nothing outside this file.
module mqnm_store #(
	parameter int DEPTH = 1500
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [7:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0] rdata
);
	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== hw/rtl/mqnm_queue.sv =====
// Two-entry queue of finished packet lengths between the loader and the scanner.
// Depends on nothing outside this file.
module mqnm_queue #(
	parameter int W = 11
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [W-1:0] push_data,
	input logic pop,
	output logic valid,
	output logic [W-1:0] data
);
	logic [1:0][W-1:0] slot_q;
	logic [1:0] fill_q;

	assign valid = fill_q != 2'd0;
	assign data = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else begin
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop & valid};
		end
	end

	always_ff @(posedge clk) begin
		if (pop && valid) begin
			if (push && fill_q == 2'd1) begin
				slot_q[0] <= push_data;
			end else begin
				slot_q[0] <= slot_q[1];
			end
			if (push && fill_q == 2'd2) begin
				slot_q[1] <= push_data;
			end
		end else if (push) begin
			slot_q[fill_q[0]] <= push_data;
		end
	end
endmodule

// ===== hw/rtl/mqnm_front.sv =====
// Loader: takes payload bytes, writes them to the store and queues the length.
// Depends on mqnm_pkg.
module mqnm_front #(
	parameter int MAX_PACKET_BYTES = mqnm_pkg::DEF_MAX_PACKET_BYTES
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] packet_byte,
	input logic last_byte,
	input logic scan_busy,
	input logic queue_empty,
	output logic mem_we,
	output logic [$clog2(MAX_PACKET_BYTES)-1:0] mem_waddr,
	output logic [7:0] mem_wdata,
	output logic push,
	output logic [$clog2(MAX_PACKET_BYTES+1)-1:0] push_len
);
	import mqnm_pkg::*;
	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int AW = $clog2(MAX_PACKET_BYTES);

	logic [CNT_W-1:0] count_q;
	logic accept, room;

	// The store is shared with the scanner, so a new payload waits until it is done.
	assign in_ready = queue_empty && !scan_busy;
	assign accept = in_valid && in_ready;
	assign room = count_q < CNT_W'(MAX_PACKET_BYTES);

	assign mem_we = accept && room;
	assign mem_waddr = count_q[AW-1:0];
	assign mem_wdata = packet_byte;
	assign push = accept && last_byte;
	assign push_len = count_q + {{(CNT_W-1){1'b0}}, room};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= last_byte ? '0 : push_len;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PACKET_BYTES))
		else $error("byte count beyond store");
	a_no_load_while_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_busy |-> !mem_we)
		else $error("store written during a scan");
	a_push_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> count_q == '0)
		else $error("count not cleared after last byte");
`endif
endmodule

// ===== hw/rtl/mqnm_scan.sv =====
// Scanner: walks the stored payload as a DNS message and produces the verdict.
// Depends on mqnm_pkg; reads the store through one registered port.
module mqnm_scan #(
	parameter int MAX_PACKET_BYTES = mqnm_pkg::DEF_MAX_PACKET_BYTES,
	parameter int NAME_CHARS = mqnm_pkg::DEF_NAME_CHARS,
	parameter int STEP_LIMIT = mqnm_pkg::DEF_STEP_LIMIT,
	parameter int DECODED_LIMIT = mqnm_pkg::DEF_DECODED_LIMIT
) (
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	input logic [$clog2(MAX_PACKET_BYTES+1)-1:0] job_len,
	output logic job_pop,
	output logic busy,
	input logic [NAME_CHARS-1:0][7:0] host_name,
	input logic [mqnm_pkg::CFG_NAME_LEN_W-1:0] name_length,
	output logic mem_re,
	output logic [$clog2(MAX_PACKET_BYTES)-1:0] mem_raddr,
	input logic [7:0] mem_rdata,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] verdict
);
	import mqnm_pkg::*;
	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int AW = $clog2(MAX_PACKET_BYTES);
	localparam int STEP_W = $clog2(STEP_LIMIT + 1);
	localparam int DL_W = $clog2(DECODED_LIMIT);
	localparam int HI_W = $clog2(NAME_CHARS);
	localparam int S_W = OFF_W + 1;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_HDR2 = 11'b00000000010,
		S_HDR4 = 11'b00000000100,
		S_HDR5 = 11'b00000001000,
		S_QSTART = 11'b00000010000,
		S_NSTEP = 11'b00000100000,
		S_LAB = 11'b00001000000,
		S_PTR = 11'b00010000000,
		S_CHR = 11'b00100000000,
		S_QEND = 11'b01000000000,
		S_TYPE = 11'b10000000000
	} state_t;

	state_t st_q, st_d;
	logic [CNT_W-1:0] n_q, n_d;
	logic [OFF_W-1:0] qleft_q, qleft_d, off_q, off_d, scan_q, scan_d;
	logic [OFF_W-1:0] res_q, res_d, nx_q, nx_d;
	logic [7:0] hi_q, hi_d, lab_q, lab_d, cnt_q, cnt_d;
	logic [STEP_W-1:0] steps_q, steps_d;
	logic [DL_W-1:0] dlen_q, dlen_d;
	logic ptr_q, ptr_d, eq_q, eq_d, hit_q, hit_d, tfirst_q, tfirst_d;
	logic out_valid_q, out_valid_d;
	verdict_t verdict_q, verdict_d;
	logic [OFF_W-1:0] raddr;
	logic [S_W-1:0] n_ext;
	logic [7:0] cmp_char;
	logic char_ok, same;
	logic [OFF_W-1:0] nxt;

	assign n_ext = S_W'(n_q);
	assign busy = st_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign verdict = verdict_q;
	assign mem_raddr = raddr[AW-1:0];

	// Characters are compared in decode order against the host name position.
	assign cmp_char = (st_q == S_LAB) ? DOT_CHAR : mem_rdata;
	assign char_ok = (DL_W + 1)'(dlen_q) < (DL_W + 1)'(name_length)
		&& (DL_W + 1)'(dlen_q) < (DL_W + 1)'(NAME_CHARS)
		&& fold_case(cmp_char) == fold_case(host_name[dlen_q[HI_W-1:0]]);
	assign same = eq_q && name_length != '0
		&& 32'(name_length) <= NAME_CHARS
		&& (DL_W + 1)'(dlen_q) == (DL_W + 1)'(name_length);
	assign nxt = ptr_q ? res_q : scan_q;

	always_comb begin
		st_d = st_q;
		n_d = n_q;
		qleft_d = qleft_q;
		off_d = off_q;
		scan_d = scan_q;
		res_d = res_q;
		nx_d = nx_q;
		hi_d = hi_q;
		lab_d = lab_q;
		cnt_d = cnt_q;
		steps_d = steps_q;
		dlen_d = dlen_q;
		ptr_d = ptr_q;
		eq_d = eq_q;
		hit_d = hit_q;
		tfirst_d = tfirst_q;
		out_valid_d = out_valid_q && !out_ready;
		verdict_d = verdict_q;
		job_pop = 1'b0;
		mem_re = 1'b0;
		raddr = '0;
		unique case (st_q)
			S_IDLE: begin
				if (job_valid && !out_valid_q) begin
					job_pop = 1'b1;
					n_d = job_len;
					if (job_len < CNT_W'(HDR_BYTES)) begin
						verdict_d = V_SHORT;
						out_valid_d = 1'b1;
					end else begin
						mem_re = 1'b1;
						raddr = OFF_W'(2);
						st_d = S_HDR2;
					end
				end
			end
			S_HDR2: begin
				if (mem_rdata[QR_BIT]) begin
					verdict_d = V_RESPONSE;
					out_valid_d = 1'b1;
					st_d = S_IDLE;
				end else begin
					mem_re = 1'b1;
					raddr = OFF_W'(4);
					st_d = S_HDR4;
				end
			end
			S_HDR4: begin
				hi_d = mem_rdata;
				mem_re = 1'b1;
				raddr = OFF_W'(5);
				st_d = S_HDR5;
			end
			S_HDR5: begin
				qleft_d = {hi_q, mem_rdata};
				off_d = OFF_W'(HDR_BYTES);
				hit_d = 1'b0;
				st_d = S_QSTART;
			end
			S_QSTART: begin
				if (qleft_q != '0 && S_W'(off_q) < n_ext) begin
					scan_d = off_q;
					res_d = '0;
					ptr_d = 1'b0;
					steps_d = '0;
					dlen_d = '0;
					eq_d = 1'b1;
					st_d = S_NSTEP;
				end else begin
					verdict_d = hit_q ? V_ANSWER : V_NO_MATCH;
					out_valid_d = 1'b1;
					st_d = S_IDLE;
				end
			end
			S_NSTEP: begin
				if (S_W'(scan_q) < n_ext && steps_q < STEP_W'(STEP_LIMIT)) begin
					mem_re = 1'b1;
					raddr = scan_q;
					st_d = S_LAB;
				end else begin
					st_d = S_QEND;
				end
			end
			S_LAB: begin
				steps_d = steps_q + 1'b1;
				if (mem_rdata[7:6] == 2'b11) begin
					if (S_W'(scan_q) + 1'b1 >= n_ext) begin
						verdict_d = hit_q ? V_ANSWER : V_NO_MATCH;
						out_valid_d = 1'b1;
						st_d = S_IDLE;
					end else begin
						if (!ptr_q) begin
							res_d = scan_q + OFF_W'(2);
						end
						lab_d = mem_rdata;
						mem_re = 1'b1;
						raddr = scan_q + 1'b1;
						st_d = S_PTR;
					end
				end else if (mem_rdata == 8'd0) begin
					scan_d = scan_q + 1'b1;
					st_d = S_QEND;
				end else if (S_W'(scan_q) + 1'b1 + S_W'(mem_rdata) > n_ext
					|| 10'(dlen_q) + 10'(mem_rdata) + 10'd1 >= 10'(DECODED_LIMIT)) begin
					verdict_d = hit_q ? V_ANSWER : V_NO_MATCH;
					out_valid_d = 1'b1;
					st_d = S_IDLE;
				end else begin
					if (dlen_q != '0) begin
						eq_d = eq_q && char_ok;
						dlen_d = dlen_q + 1'b1;
					end
					scan_d = scan_q + 1'b1;
					cnt_d = mem_rdata;
					mem_re = 1'b1;
					raddr = scan_q + 1'b1;
					st_d = S_CHR;
				end
			end
			S_PTR: begin
				scan_d = OFF_W'({lab_q[5:0], mem_rdata});
				ptr_d = 1'b1;
				st_d = S_NSTEP;
			end
			S_CHR: begin
				eq_d = eq_q && char_ok;
				dlen_d = dlen_q + 1'b1;
				scan_d = scan_q + 1'b1;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q > 8'd1) begin
					mem_re = 1'b1;
					raddr = scan_q + 1'b1;
				end else begin
					st_d = S_NSTEP;
				end
			end
			S_QEND: begin
				if (S_W'(nxt) + S_W'(4) > n_ext) begin
					verdict_d = hit_q ? V_ANSWER : V_NO_MATCH;
					out_valid_d = 1'b1;
					st_d = S_IDLE;
				end else begin
					nx_d = nxt;
					tfirst_d = 1'b1;
					mem_re = 1'b1;
					raddr = nxt;
					st_d = S_TYPE;
				end
			end
			S_TYPE: begin
				// Two passes: the high type byte, then the low byte and the decision.
				if (tfirst_q) begin
					hi_d = mem_rdata;
					tfirst_d = 1'b0;
					mem_re = 1'b1;
					raddr = nx_q + 1'b1;
				end else begin
					if (({hi_q, mem_rdata} == 16'(QTYPE_A)
						|| {hi_q, mem_rdata} == 16'(QTYPE_ANY)) && same) begin
						hit_d = 1'b1;
					end
					off_d = nx_q + OFF_W'(4);
					qleft_d = qleft_q - 1'b1;
					st_d = S_QSTART;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q <= n_d;
		qleft_q <= qleft_d;
		off_q <= off_d;
		scan_q <= scan_d;
		res_q <= res_d;
		nx_q <= nx_d;
		hi_q <= hi_d;
		lab_q <= lab_d;
		cnt_q <= cnt_d;
		steps_q <= steps_d;
		dlen_q <= dlen_d;
		ptr_q <= ptr_d;
		eq_q <= eq_d;
		hit_q <= hit_d;
		tfirst_q <= tfirst_d;
		verdict_q <= verdict_d;
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("scanner state not one-hot");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !out_valid_q)
		else $error("scan running while a verdict waits");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		busy && st_q != S_HDR2 && st_q != S_HDR4 && st_q != S_HDR5
		&& st_q != S_QSTART |-> steps_q <= STEP_W'(STEP_LIMIT))
		else $error("step count beyond limit");
	a_pop_start: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid && !busy)
		else $error("job taken while busy");
`endif
endmodule

// ===== hw/rtl/mdns_query_name_matcher.sv =====
// mDNS query name matcher, top level: configuration registers, loader, queue,
// store and scanner. Depends on mqnm_pkg and all mqnm_* modules.
//
// Usage: payload bytes arrive on in_valid/in_ready with packet_byte and
// last_byte; one request is one byte. Bytes past MAX_PACKET_BYTES are dropped.
// The byte marked last produces exactly one verdict on out_valid/out_ready.
// Loading writes each accepted byte to the store. The scan then starts and reads
// the store through its single read port: the header, then each label step,
// pointer step and name character, and then each question's type and the start
// of the next question. For a too-short packet the length passes through the
// queue and the scanner raises out_valid from idle without reading the store.
// in_ready is low while a scan runs or a length waits in the queue; a verdict
// waiting in the output register does not block loading of the next payload,
// but the next scan waits until that verdict is taken. Configuration is to be
// written through cfg_write/cfg_index/cfg_data only while the block is idle;
// the block does not enforce this. Reset clears all control state and the host
// name; the store holds nothing valid after reset.
module mdns_query_name_matcher #(
	parameter int MAX_PACKET_BYTES = mqnm_pkg::DEF_MAX_PACKET_BYTES,
	parameter int NAME_CHARS = mqnm_pkg::DEF_NAME_CHARS,
	parameter int STEP_LIMIT = mqnm_pkg::DEF_STEP_LIMIT,
	parameter int DECODED_LIMIT = mqnm_pkg::DEF_DECODED_LIMIT
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [mqnm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mqnm_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] packet_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] verdict
);
	import mqnm_pkg::*;
	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int AW = $clog2(MAX_PACKET_BYTES);

	logic [NAME_CHARS-1:0][7:0] host_q;
	logic [CFG_NAME_LEN_W-1:0] name_len_q;
	logic mem_we, mem_re, push, q_valid, pop, scan_busy;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata, mem_rdata;
	logic [CNT_W-1:0] push_len, q_data;

	for (genvar p = 0; p < NAME_CHARS; p++) begin : g_host
		if (p < CFG_NAME_REGS * CFG_CHARS_PER_REG) begin : g_cfg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					host_q[p] <= '0;
				end else if (cfg_write
					&& cfg_index == CFG_IDX_W'(p / CFG_CHARS_PER_REG)) begin
					host_q[p] <= cfg_data[8 * (p % CFG_CHARS_PER_REG) +: 8];
				end
			end
		end else begin : g_none
			assign host_q[p] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q <= '0;
		end else if (cfg_write && cfg_index == CFG_NAME_LENGTH) begin
			name_len_q <= cfg_data[CFG_NAME_LEN_W-1:0];
		end
	end

	mqnm_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.packet_byte(packet_byte), .last_byte(last_byte),
		.scan_busy(scan_busy), .queue_empty(!q_valid),
		.mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
		.push(push), .push_len(push_len)
	);

	mqnm_queue #(.W(CNT_W)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_len),
		.pop(pop), .valid(q_valid), .data(q_data)
	);

	mqnm_store #(.DEPTH(MAX_PACKET_BYTES)) u_store (
		.clk(clk),
		.we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	mqnm_scan #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES),
		.NAME_CHARS(NAME_CHARS),
		.STEP_LIMIT(STEP_LIMIT),
		.DECODED_LIMIT(DECODED_LIMIT)
	) u_scan (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job_len(q_data), .job_pop(pop), .busy(scan_busy),
		.host_name(host_q), .name_length(name_len_q),
		.mem_re(mem_re), .mem_raddr(mem_raddr), .mem_rdata(mem_rdata),
		.out_valid(out_valid), .out_ready(out_ready), .verdict(verdict)
	);
endmodule
